// File: rtl/core/bsd_pkg.sv
// Shared types and constants for the descending bubble sorter.
// Used by the controller, the datapath and the top level; depends on nothing.
package bsd_pkg;

	// Widths fixed by the item fields.
	localparam int DATA_PORT_WIDTH = 32;
	localparam int CMP_WIDTH       = 12;
	localparam logic [CMP_WIDTH-1:0] CMP_MAX = '1;

	// Controller states, one-hot.
	typedef enum logic [6:0] {
		S_LOAD       = 7'b0000001,
		S_PRIME      = 7'b0000010,
		S_FIRST      = 7'b0000100,
		S_CMP        = 7'b0001000,
		S_TAIL       = 7'b0010000,
		S_EMIT_PRIME = 7'b0100000,
		S_EMIT       = 7'b1000000
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // store the accepted item, or mark overflow
		logic prime;       // read entry 0, clear the pair index and swap flag
		logic take_first;  // move entry 0 into the carry register
		logic compare;     // compare carry with the next entry, write back the larger
		logic write_tail;  // write the carry into the last entry of the list
		logic emit;        // present one sorted item
		logic finish;      // clear list state after the final item
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic single;      // the list holds one element
		logic pair_last;   // the current pair is the last of the pass
		logic emit_last;   // the current item is the last to emit
		logic swapped;     // the pass so far has made a swap
	} sts_t;

endpackage

// File: rtl/core/bsd_ctrl.sv
// Controller state machine for the descending bubble sorter.
// Depends on bsd_pkg for the state, command and status types.
module bsd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          last,
	input  bsd_pkg::sts_t sts,
	output bsd_pkg::cmd_t cmd,
	output logic          busy
);

	bsd_pkg::state_t state_q;
	bsd_pkg::state_t state_d;

	// The block takes items only while it is loading a list.
	assign busy = (state_q != bsd_pkg::S_LOAD);

	// Command decode and next state.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			bsd_pkg::S_LOAD: begin
				if (start) begin
					cmd.load = 1'b1;
					if (last) state_d = bsd_pkg::S_PRIME;
				end
			end
			bsd_pkg::S_PRIME: begin
				cmd.prime = 1'b1;
				state_d   = bsd_pkg::S_FIRST;
			end
			bsd_pkg::S_FIRST: begin
				cmd.take_first = 1'b1;
				state_d = sts.single ? bsd_pkg::S_EMIT_PRIME : bsd_pkg::S_CMP;
			end
			bsd_pkg::S_CMP: begin
				cmd.compare = 1'b1;
				if (sts.pair_last) state_d = bsd_pkg::S_TAIL;
			end
			bsd_pkg::S_TAIL: begin
				cmd.write_tail = 1'b1;
				state_d = sts.swapped ? bsd_pkg::S_PRIME : bsd_pkg::S_EMIT_PRIME;
			end
			bsd_pkg::S_EMIT_PRIME: begin
				cmd.prime = 1'b1;
				state_d   = bsd_pkg::S_EMIT;
			end
			bsd_pkg::S_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.emit_last) begin
					cmd.finish = 1'b1;
					state_d    = bsd_pkg::S_LOAD;
				end
			end
			default: begin
				state_d = bsd_pkg::S_LOAD;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsd_pkg::S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// The block only returns to loading straight after the final item.
	a_idle_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(state_q == bsd_pkg::S_EMIT && sts.emit_last))
		else $error("busy fell without the final item of a list");

	// A final item starts the sort at once.
	a_last_starts_sort: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last) |=> (state_q == bsd_pkg::S_PRIME))
		else $error("final item did not start the sort");

endmodule

// File: rtl/core/bsd_datapath.sv
// Datapath of the descending bubble sorter: element memory, carry register,
// pair index, list counters and result ports. Depends on bsd_pkg.
module bsd_datapath #(
	parameter int MAX_ITEMS   = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  bsd_pkg::cmd_t                        cmd,
	input  logic [bsd_pkg::DATA_PORT_WIDTH-1:0]  value,
	output bsd_pkg::sts_t                        sts,
	output logic                                 strobe,
	output logic [bsd_pkg::DATA_PORT_WIDTH-1:0]  sorted_value,
	output logic                                 end_of_list,
	output logic [bsd_pkg::CMP_WIDTH-1:0]        comparison_count,
	output logic                                 overflow
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int NW = $clog2(MAX_ITEMS + 1);
	localparam int OW = bsd_pkg::DATA_PORT_WIDTH;
	localparam logic [NW-1:0] FULL_COUNT = NW'(MAX_ITEMS);

	logic [VALUE_WIDTH-1:0] mem [MAX_ITEMS];
	logic [VALUE_WIDTH-1:0] rd_q;
	logic [VALUE_WIDTH-1:0] carry_q;
	logic [AW-1:0]          k_q;
	logic [NW-1:0]          count_q;
	logic [bsd_pkg::CMP_WIDTH-1:0] cmp_q;
	logic                   swapped_q;
	logic                   dropped_q;

	logic [NW-1:0]          k_ext;
	logic [AW-1:0]          tail_idx;
	logic [AW-1:0]          rd_idx;
	logic                   full;
	logic                   less;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [VALUE_WIDTH-1:0] wr_data;

	assign k_ext    = NW'(k_q);
	assign tail_idx = AW'(count_q - NW'(1));
	assign full     = (count_q == FULL_COUNT);
	assign less     = (carry_q < rd_q);

	// Status for the controller.
	assign sts.single    = (count_q == NW'(1));
	assign sts.pair_last = ((k_ext + NW'(2)) == count_q);
	assign sts.emit_last = ((k_ext + NW'(1)) == count_q);
	assign sts.swapped   = swapped_q;

	// Read address: entry 0 when priming, otherwise one or two ahead of the index.
	always_comb begin
		if (cmd.prime) begin
			rd_idx = '0;
		end else if (cmd.compare) begin
			rd_idx = k_q + AW'(2);
		end else begin
			rd_idx = k_q + AW'(1);
		end
	end

	// Single write port: loading, the larger of a pair, or the tail of a pass.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = k_q;
		wr_data = rd_q;
		if (cmd.load) begin
			wr_en   = !full;
			wr_addr = count_q[AW-1:0];
			wr_data = VALUE_WIDTH'(value);
		end else if (cmd.compare) begin
			wr_en   = 1'b1;
			wr_addr = k_q;
			wr_data = less ? rd_q : carry_q;
		end else if (cmd.write_tail) begin
			wr_en   = 1'b1;
			wr_addr = tail_idx;
			wr_data = carry_q;
		end
	end

	// Element memory with a registered read.
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_idx];
	end

	// The carry holds the element being bubbled; it keeps the smaller of each pair.
	always_ff @(posedge clk) begin
		if (cmd.take_first) begin
			carry_q <= rd_q;
		end else if (cmd.compare && !less) begin
			carry_q <= rd_q;
		end
	end

	// Pair index, list counters and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= '0;
			count_q   <= '0;
			cmp_q     <= '0;
			swapped_q <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (full) dropped_q <= 1'b1;
				else      count_q   <= count_q + NW'(1);
			end
			if (cmd.prime) begin
				k_q       <= '0;
				swapped_q <= 1'b0;
			end
			if (cmd.compare || cmd.emit) k_q <= k_q + AW'(1);
			if (cmd.compare) begin
				if (less) swapped_q <= 1'b1;
				if (cmp_q != bsd_pkg::CMP_MAX) cmp_q <= cmp_q + bsd_pkg::CMP_WIDTH'(1);
			end
			if (cmd.finish) begin
				count_q   <= '0;
				cmp_q     <= '0;
				dropped_q <= 1'b0;
			end
		end
	end

	// Result ports.
	assign strobe           = cmd.emit;
	assign sorted_value     = OW'(rd_q);
	assign end_of_list      = cmd.emit && sts.emit_last;
	assign comparison_count = cmp_q;
	assign overflow         = dropped_q;

	// Items are only emitted from a non-empty list.
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (count_q != '0))
		else $error("item emitted from an empty list");

	// A comparison never reaches beyond the loaded elements.
	a_compare_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.compare |-> ((k_ext + NW'(2)) <= count_q))
		else $error("comparison beyond the end of the list");

	// The comparison total holds steady while a list is emitted.
	a_count_stable_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && !cmd.finish) |=> $stable(cmp_q))
		else $error("comparison total changed during emission");

endmodule

// File: rtl/core/bubble_sort_descending.sv
// Top level of the descending bubble sorter.
// Instantiates bsd_ctrl and bsd_datapath; depends on bsd_pkg.
//
// Items are taken one per cycle while busy is low, at each edge with start high;
// an item with last set closes the list. Up to MAX_ITEMS elements are kept and
// further ones only set the overflow flag. The list is then sorted in place in a
// single-port memory: each pass runs a read prime, a carry load, a compare and
// write per adjacent pair and a tail write, and passes repeat until one makes no
// swap; a single element needs only the read prime and carry load. The results
// then come out largest first, one per cycle with strobe high, from a registered
// memory read. The receiver cannot stall: each result is valid only in the cycle
// its strobe is high. busy stays high from the final item of a list until the
// cycle after its last result.
module bubble_sort_descending #(
	parameter int MAX_ITEMS   = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [bsd_pkg::DATA_PORT_WIDTH-1:0]  value,
	input  logic                                 last,
	output logic                                 strobe,
	output logic [bsd_pkg::DATA_PORT_WIDTH-1:0]  sorted_value,
	output logic                                 end_of_list,
	output logic [bsd_pkg::CMP_WIDTH-1:0]        comparison_count,
	output logic                                 overflow
);

	bsd_pkg::cmd_t cmd;
	bsd_pkg::sts_t sts;

	// Sequencing of load, sort passes and emission.
	bsd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (last),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Storage, compare-and-swap and result ports.
	bsd_datapath #(
		.MAX_ITEMS   (MAX_ITEMS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.value            (value),
		.sts              (sts),
		.strobe           (strobe),
		.sorted_value     (sorted_value),
		.end_of_list      (end_of_list),
		.comparison_count (comparison_count),
		.overflow         (overflow)
	);

endmodule
